[rtl/scm_pkg.sv]
// Shared types, constants and helpers of the substring matcher.
`timescale 1ns / 1ps
`default_nettype none

package scm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int UNIT_W      = 32;
    localparam int LEN_W       = 5;
    localparam int CMD_W       = 2;
    localparam int PIDX_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PATTERN = 2'd0,
        CMD_TEXT    = 2'd1,
        CMD_END     = 2'd2,
        CMD_NONE    = 2'd3
    } scm_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LEN  = 2'd0,
        REG_TEXT_WIDE    = 2'd1,
        REG_PATTERN_WIDE = 2'd2,
        REG_UNUSED       = 2'd3
    } scm_reg_t;

    // Control broadcast to every window cell.
    typedef struct packed {
        logic shift;
        logic clear;
        logic text_wide;
        logic pattern_wide;
    } scm_cell_ctrl_t;

    // A narrow unit is compared by its low 16 bits only.
    function automatic logic [UNIT_W-1:0] unit_mask(input logic wide);
        logic [UNIT_W-1:0] m;
        m = wide ? {UNIT_W{1'b1}} : {{(UNIT_W-16){1'b0}}, {16{1'b1}}};
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/scm_cell.sv]
// One window cell: holds a text unit of fixed age and compares the unit that enters it with its pattern unit.
`timescale 1ns / 1ps
`default_nettype none

module scm_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire scm_pkg::scm_cell_ctrl_t     ctrl,
    input  wire logic [scm_pkg::UNIT_W-1:0]  up_unit,
    input  wire logic                        up_valid,
    input  wire logic [scm_pkg::UNIT_W-1:0]  pattern_unit,
    input  wire logic                        active,
    output logic      [scm_pkg::UNIT_W-1:0]  unit,
    output logic                             valid,
    output logic                             hit
);
    import scm_pkg::*;

    logic [UNIT_W-1:0] unit_reg;
    logic [UNIT_W-1:0] unit_next;
    logic              valid_reg;
    logic              valid_next;

    always_comb
    begin
        unit_next  = unit_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            unit_next  = up_unit;
            valid_next = up_valid;
        end
    end

    // The compare looks at the unit that enters this cell in the shifting cycle.
    assign hit = !active || (up_valid &&
                 ((up_unit & unit_mask(ctrl.text_wide)) ==
                  (pattern_unit & unit_mask(ctrl.pattern_wide))));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
    end

    assign unit  = unit_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

[rtl/substring_contains_matcher.sv]
// Top level of the substring matcher: pattern store, cell chain and result register.
// An end-of-text result is registered and appears in the cycle after it is accepted.
// One transaction per cycle while not refused; the window compare is combinational.
// Input is refused only while a result waits in the output register and is not taken.
// Reset clears the window, the match flag, the output register and the registers to zero;
// the pattern store holds no defined value until written.
`timescale 1ns / 1ps
`default_nettype none

module substring_contains_matcher (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // cmd[1:0], pattern_index[5:2], unit_value[37:6], zero fill above
    input  wire logic [scm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // found[0], zero fill above
    output logic      [scm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [scm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [scm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import scm_pkg::*;

    scm_cmd_t           cmd;
    logic [PIDX_W-1:0]  pattern_index;
    logic [UNIT_W-1:0]  unit_value;
    logic               accept;

    logic [LEN_W-1:0]   pattern_len_reg;
    logic               text_wide_reg;
    logic               pattern_wide_reg;
    logic [LEN_W-1:0]   plen_eff;

    logic [MAX_PATTERN-1:0][UNIT_W-1:0] pattern_reg;

    logic [MAX_PATTERN-1:0][UNIT_W-1:0] cell_unit;
    logic [MAX_PATTERN-1:0]             cell_valid;
    logic [MAX_PATTERN-1:0]             cell_hit;
    scm_cell_ctrl_t                     ctrl;

    logic match_seen_reg;
    logic match_seen_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic found_reg;
    logic found_next;
    logic window_match;

    assign cmd           = scm_cmd_t'(s_axis_tdata[CMD_W-1:0]);
    assign pattern_index = s_axis_tdata[CMD_W +: PIDX_W];
    assign unit_value    = s_axis_tdata[CMD_W+PIDX_W +: UNIT_W];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign plen_eff = (pattern_len_reg > LEN_W'(MAX_PATTERN)) ?
                      LEN_W'(MAX_PATTERN) : pattern_len_reg;

    always_comb
    begin
        ctrl.shift        = accept && (cmd == CMD_TEXT);
        ctrl.clear        = accept && (cmd == CMD_END);
        ctrl.text_wide    = text_wide_reg;
        ctrl.pattern_wide = pattern_wide_reg;
    end

    // Cell k holds the text unit of age k and faces pattern unit plen-1-k.
    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic [IDX_W-1:0]  sel;
            logic              active;
            logic [UNIT_W-1:0] up_unit;
            logic              up_valid;

            assign sel    = IDX_W'(plen_eff - LEN_W'(k) - LEN_W'(1));
            assign active = LEN_W'(k) < plen_eff;

            if (k == 0)
            begin : g_head
                assign up_unit  = unit_value;
                assign up_valid = 1'b1;
            end
            else
            begin : g_body
                assign up_unit  = cell_unit[k-1];
                assign up_valid = cell_valid[k-1];
            end

            scm_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .up_unit      (up_unit),
                .up_valid     (up_valid),
                .pattern_unit (pattern_reg[sel]),
                .active       (active),
                .unit         (cell_unit[k]),
                .valid        (cell_valid[k]),
                .hit          (cell_hit[k])
            );
        end
    endgenerate

    assign window_match = (plen_eff != '0) && (&cell_hit);

    always_comb
    begin
        match_seen_next = match_seen_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        found_next      = found_reg;
        if (accept)
        begin
            case (cmd)
                CMD_TEXT:
                begin
                    if (window_match)
                    begin
                        match_seen_next = 1'b1;
                    end
                end
                CMD_END:
                begin
                    // A wide pattern can never occur in a narrow text.
                    found_next      = !(!text_wide_reg && pattern_wide_reg) &&
                                      ((plen_eff == '0) || match_seen_reg);
                    out_valid_next  = 1'b1;
                    match_seen_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg  <= '0;
            text_wide_reg    <= 1'b0;
            pattern_wide_reg <= 1'b0;
            match_seen_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (scm_reg_t'(cfg_index))
                    REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[LEN_W-1:0];
                    REG_TEXT_WIDE:    text_wide_reg    <= cfg_data[0];
                    REG_PATTERN_WIDE: pattern_wide_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            match_seen_reg <= match_seen_next;
            out_valid_reg  <= out_valid_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cmd == CMD_PATTERN) && (32'(pattern_index) < MAX_PATTERN))
        begin
            pattern_reg[pattern_index[IDX_W-1:0]] <= unit_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, found_reg};

endmodule

`default_nettype wire
